>>> src/gpi_pkg.sv
// ============================================================================
// gpi_pkg
// Shared constants, codes, reset table and controller/datapath interface
// types for the gripper gap / pulse interpolator.
// ============================================================================
`default_nettype none

package gpi_pkg;

    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int VAL_W      = 12;
    localparam int CFG_W      = 5;
    localparam int RESET_POINTS = 11;
    localparam int QUOT_W     = VAL_W;
    localparam int DCNT_W     = $clog2(QUOT_W);

    // item modes
    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_G2P  = 2'd1;
    localparam logic [1:0] MODE_P2G  = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;

    localparam logic [CFG_W-1:0] COUNT_RESET = 5'd11;

    // factory breakpoints, slots beyond the list are zero
    function automatic logic [VAL_W-1:0] reset_pulse(input int i);
        logic [VAL_W-1:0] v;
        case (i)
            0:       v = 12'd500;
            1:       v = 12'd700;
            2:       v = 12'd900;
            3:       v = 12'd1050;
            4:       v = 12'd1150;
            5:       v = 12'd1200;
            6:       v = 12'd1250;
            7:       v = 12'd1300;
            8:       v = 12'd1400;
            9:       v = 12'd1500;
            10:      v = 12'd1600;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [VAL_W-1:0] reset_gap(input int i);
        logic [VAL_W-1:0] v;
        case (i)
            0:       v = 12'd580;
            1:       v = 12'd560;
            2:       v = 12'd500;
            3:       v = 12'd440;
            4:       v = 12'd360;
            5:       v = 12'd290;
            6:       v = 12'd280;
            7:       v = 12'd240;
            8:       v = 12'd160;
            9:       v = 12'd60;
            default: v = '0;
        endcase
        return v;
    endfunction

    typedef struct packed {
        logic latch;
        logic write_point;
        logic scan_clear;
        logic scan_step;
        logic mul_base;
        logic mul_slope;
        logic div_load;
        logic div_step;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic run_query;
        logic scan_last;
        logic need_interp;
        logic div_last;
    } dp_status_t;

endpackage

`default_nettype wire

>>> src/gpi_ctrl.sv
// ============================================================================
// gpi_ctrl
// Sequencer: decode, breakpoint scan, two multiply steps, serial divide,
// result strobe.
// ============================================================================
`default_nettype none

module gpi_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    output logic                   done,
    output gpi_pkg::ctrl_cmd_t     cmd,
    input  wire gpi_pkg::dp_status_t sts
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_CHECK,
        S_MUL_BASE,
        S_MUL_SLOPE,
        S_DIV_LOAD,
        S_DIV,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.run_query)
                begin
                    cmd.scan_clear = 1'b1;
                    state_next     = S_SCAN;
                end
                else
                begin
                    cmd.write_point = 1'b1;
                    state_next      = S_FINISH;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = sts.need_interp ? S_MUL_BASE : S_FINISH;
            end
            S_MUL_BASE:
            begin
                cmd.mul_base = 1'b1;
                state_next   = S_MUL_SLOPE;
            end
            S_MUL_SLOPE:
            begin
                cmd.mul_slope = 1'b1;
                state_next    = S_DIV_LOAD;
            end
            S_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

`default_nettype wire

>>> src/gpi_datapath.sv
// ============================================================================
// gpi_datapath
// Breakpoint table, count register, segment scan registers, shared
// multiplier, restoring divider and result registers.
// ============================================================================
`default_nettype none

module gpi_datapath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire gpi_pkg::ctrl_cmd_t             cmd,
    output gpi_pkg::dp_status_t                 sts,
    input  wire logic                           point_count_we,
    input  wire logic [gpi_pkg::CFG_W-1:0]      point_count,
    input  wire logic [1:0]                     mode,
    input  wire logic [3:0]                     point_index,
    input  wire logic [gpi_pkg::VAL_W-1:0]      point_pulse,
    input  wire logic [gpi_pkg::VAL_W-1:0]      point_gap,
    input  wire logic [gpi_pkg::VAL_W-1:0]      query_gap,
    input  wire logic [gpi_pkg::VAL_W-1:0]      query_pulse,
    output logic [gpi_pkg::VAL_W-1:0]           pulse_out,
    output logic [gpi_pkg::VAL_W-1:0]           gap_out,
    output logic [1:0]                          status
);

    localparam int VW = gpi_pkg::VAL_W;
    localparam int IW = gpi_pkg::IDX_W;
    localparam int CW = gpi_pkg::CNT_W;
    localparam int MP = gpi_pkg::MAX_POINTS;
    localparam int QW = gpi_pkg::QUOT_W;

    // configuration and latched word
    logic [gpi_pkg::CFG_W-1:0] point_count_reg;
    logic [1:0]                mode_reg;
    logic [3:0]                idx_reg;
    logic [VW-1:0]             lp_reg, lg_reg, q_reg;
    logic [CW-1:0]             n_reg;

    // breakpoint table
    logic [VW-1:0] tab_pulse_reg [MP];
    logic [VW-1:0] tab_gap_reg   [MP];

    // scan state
    logic [IW-1:0] scan_cnt_reg;
    logic [VW-1:0] first_p_reg, first_g_reg, last_p_reg, last_g_reg;
    logic [VW-1:0] prev_p_reg, prev_g_reg;
    logic [VW-1:0] seg_ap_reg, seg_ag_reg, seg_bp_reg, seg_bg_reg;
    logic          found_reg;

    // arithmetic state
    logic signed [27:0]         acc_reg;
    logic [12:0]                part_reg;
    logic [QW-1:0]              sh_reg;
    logic [gpi_pkg::DCNT_W-1:0] div_cnt_reg;

    logic [VW-1:0] pulse_out_reg, gap_out_reg;
    logic [1:0]    status_reg;

    logic          is_g2p, is_query, idx_ok, table_empty;
    logic [VW-1:0] cur_p, cur_g;
    logic          seg_match;
    logic          end_first, end_last, zero_width;
    logic signed [12:0] base_s, den_s, diff_s, delta_s, mul_a, mul_b;
    logic signed [25:0] prod;
    logic [24:0]   top;
    logic [13:0]   div_d, trial;
    logic          trial_ge;
    logic [VW-1:0] interp_v, first_y, last_y, seg_ay, result_v;
    logic [CW-1:0] n_next;

    assign is_g2p      = (mode_reg == gpi_pkg::MODE_G2P);
    assign is_query    = is_g2p || (mode_reg == gpi_pkg::MODE_P2G);
    assign idx_ok      = (int'(idx_reg) < MP);
    assign table_empty = (n_reg == '0);

    assign n_next = (int'(point_count_reg) > MP) ? CW'(MP) : CW'(point_count_reg);

    assign cur_p = tab_pulse_reg[scan_cnt_reg];
    assign cur_g = tab_gap_reg[scan_cnt_reg];

    // first segment that brackets the query
    assign seg_match = is_g2p ? ((q_reg <= prev_g_reg) && (q_reg >= cur_g))
                              : ((q_reg >= prev_p_reg) && (q_reg <= cur_p));

    assign end_first = (n_reg == CW'(1)) ||
                       (is_g2p ? (q_reg >= first_g_reg) : (q_reg <= first_p_reg));
    assign end_last  = is_g2p ? (q_reg <= last_g_reg) : (q_reg >= last_p_reg);
    assign zero_width = is_g2p ? (seg_ag_reg == seg_bg_reg) : (seg_ap_reg == seg_bp_reg);

    assign sts.run_query   = is_query && !table_empty;
    assign sts.scan_last   = ((CW'(scan_cnt_reg) + CW'(1)) == n_reg);
    assign sts.need_interp = !end_first && !end_last && found_reg && !zero_width;
    assign sts.div_last    = (div_cnt_reg == gpi_pkg::DCNT_W'(QW - 1));

    // interpolation operands, y = base + diff * delta / den
    always_comb
    begin
        if (is_g2p)
        begin
            base_s  = $signed({1'b0, seg_ap_reg});
            den_s   = $signed({1'b0, seg_ag_reg}) - $signed({1'b0, seg_bg_reg});
            diff_s  = $signed({1'b0, seg_ag_reg}) - $signed({1'b0, q_reg});
            delta_s = $signed({1'b0, seg_bp_reg}) - $signed({1'b0, seg_ap_reg});
        end
        else
        begin
            base_s  = $signed({1'b0, seg_ag_reg});
            den_s   = $signed({1'b0, seg_bp_reg}) - $signed({1'b0, seg_ap_reg});
            diff_s  = $signed({1'b0, q_reg}) - $signed({1'b0, seg_ap_reg});
            delta_s = $signed({1'b0, seg_bg_reg}) - $signed({1'b0, seg_ag_reg});
        end
    end

    // one shared multiplier
    assign mul_a = cmd.mul_base ? base_s : diff_s;
    assign mul_b = cmd.mul_base ? den_s : delta_s;
    assign prod  = mul_a * mul_b;

    // dividend 2*base*den + 2*num + den, floored at zero
    assign top      = acc_reg[27] ? '0 : acc_reg[24:0];
    assign div_d    = {den_s[12:0], 1'b0};
    assign trial    = {part_reg, sh_reg[QW-1]};
    assign trial_ge = (trial >= div_d);

    always_comb
    begin
        interp_v = sh_reg;
        if (is_g2p)
        begin
            if (interp_v > last_p_reg)
                interp_v = last_p_reg;
            if (interp_v < first_p_reg)
                interp_v = first_p_reg;
        end
    end

    assign first_y = is_g2p ? first_p_reg : first_g_reg;
    assign last_y  = is_g2p ? last_p_reg : last_g_reg;
    assign seg_ay  = is_g2p ? seg_ap_reg : seg_ag_reg;

    always_comb
    begin
        if (end_first)
            result_v = first_y;
        else if (end_last || !found_reg)
            result_v = last_y;
        else if (zero_width)
            result_v = seg_ay;
        else
            result_v = interp_v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= gpi_pkg::COUNT_RESET;
            for (int i = 0; i < MP; i++)
            begin
                tab_pulse_reg[i] <= gpi_pkg::reset_pulse(i);
                tab_gap_reg[i]   <= gpi_pkg::reset_gap(i);
            end
        end
        else
        begin
            if (point_count_we)
                point_count_reg <= point_count;
            if (cmd.write_point && (mode_reg == gpi_pkg::MODE_LOAD) && idx_ok)
            begin
                tab_pulse_reg[IW'(idx_reg)] <= lp_reg;
                tab_gap_reg[IW'(idx_reg)]   <= lg_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            mode_reg <= mode;
            idx_reg  <= point_index;
            lp_reg   <= point_pulse;
            lg_reg   <= point_gap;
            q_reg    <= (mode == gpi_pkg::MODE_G2P) ? query_gap : query_pulse;
            n_reg    <= n_next;
        end

        if (cmd.scan_clear)
            scan_cnt_reg <= '0;
        if (cmd.scan_step)
        begin
            if (scan_cnt_reg == '0)
            begin
                first_p_reg <= cur_p;
                first_g_reg <= cur_g;
                found_reg   <= 1'b0;
            end
            else if (!found_reg && seg_match)
            begin
                found_reg  <= 1'b1;
                seg_ap_reg <= prev_p_reg;
                seg_ag_reg <= prev_g_reg;
                seg_bp_reg <= cur_p;
                seg_bg_reg <= cur_g;
            end
            prev_p_reg   <= cur_p;
            prev_g_reg   <= cur_g;
            last_p_reg   <= cur_p;
            last_g_reg   <= cur_g;
            scan_cnt_reg <= scan_cnt_reg + IW'(1);
        end

        if (cmd.mul_base)
            acc_reg <= $signed({prod[25], prod, 1'b0}) + $signed({{15{den_s[12]}}, den_s});
        if (cmd.mul_slope)
            acc_reg <= acc_reg + $signed({prod[25], prod, 1'b0});

        if (cmd.div_load)
        begin
            part_reg    <= top[24:12];
            sh_reg      <= top[QW-1:0];
            div_cnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            part_reg    <= trial_ge ? 13'(trial - div_d) : trial[12:0];
            sh_reg      <= {sh_reg[QW-2:0], trial_ge};
            div_cnt_reg <= div_cnt_reg + gpi_pkg::DCNT_W'(1);
        end

        if (cmd.finish)
        begin
            pulse_out_reg <= '0;
            gap_out_reg   <= '0;
            status_reg    <= gpi_pkg::STATUS_OK;
            if (mode_reg == gpi_pkg::MODE_LOAD)
            begin
                if (!idx_ok)
                    status_reg <= gpi_pkg::STATUS_BAD_INDEX;
            end
            else if (is_query)
            begin
                if (table_empty)
                    status_reg <= gpi_pkg::STATUS_EMPTY;
                else if (is_g2p)
                    pulse_out_reg <= result_v;
                else
                    gap_out_reg <= result_v;
            end
        end
    end

    assign pulse_out = pulse_out_reg;
    assign gap_out   = gap_out_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

>>> src/gripper_gap_pulse_interpolator.sv
// ============================================================================
// gripper_gap_pulse_interpolator
// Piecewise-linear conversion between servo pulse width and gripper gap
// over a loadable breakpoint table.
// ============================================================================
// An item is taken when start is high and busy is low; its single result
// appears on pulse_out, gap_out and status for one cycle with done high, and
// the receiver cannot stall it. A load, a spare-mode item or an empty-table
// query goes from decode straight to the finish state. A query first scans
// the n breakpoints in use, one table entry a cycle; when it ends on a table
// end, a flat segment or no segment it then finishes, and when it
// interpolates one shared multiplier runs two steps and a restoring divider
// retires one quotient bit a cycle. A new item may be started in the cycle
// done is high. The user must write point_count only while busy is low;
// the block itself does not enforce this.
`default_nettype none

module gripper_gap_pulse_interpolator (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [1:0]                mode,
    input  wire logic [3:0]                point_index,
    input  wire logic [gpi_pkg::VAL_W-1:0] point_pulse,
    input  wire logic [gpi_pkg::VAL_W-1:0] point_gap,
    input  wire logic [gpi_pkg::VAL_W-1:0] query_gap,
    input  wire logic [gpi_pkg::VAL_W-1:0] query_pulse,
    input  wire logic                      point_count_we,
    input  wire logic [gpi_pkg::CFG_W-1:0] point_count,
    output logic                           done,
    output logic [gpi_pkg::VAL_W-1:0]      pulse_out,
    output logic [gpi_pkg::VAL_W-1:0]      gap_out,
    output logic [1:0]                     status
);

    gpi_pkg::ctrl_cmd_t  cmd;
    gpi_pkg::dp_status_t sts;

    gpi_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .sts   (sts)
    );

    gpi_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .point_count_we (point_count_we),
        .point_count    (point_count),
        .mode           (mode),
        .point_index    (point_index),
        .point_pulse    (point_pulse),
        .point_gap      (point_gap),
        .query_gap      (query_gap),
        .query_pulse    (query_pulse),
        .pulse_out      (pulse_out),
        .gap_out        (gap_out),
        .status         (status)
    );

`ifndef SYNTHESIS
    // a result word always closes an item
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without an item in flight");

    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("busy still high with the result word");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted word did not enter the sequence");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == gpi_pkg::STATUS_EMPTY)) |-> ((pulse_out == '0) && (gap_out == '0)))
        else $error("empty table result carries a value");
`endif

endmodule

`default_nettype wire

>>> dv/gripper_gap_pulse_interpolator_tb.sv
// ============================================================================
// gripper_gap_pulse_interpolator_tb
// Self-checking bench for the gap / pulse interpolator. Loads breakpoint
// tables (ordered and scrambled), sweeps the point count and fires
// conversions in both directions. A scoreboard class keeps a private copy of
// the table, predicts every result word and compares it field by field.
// ============================================================================

module gripper_gap_pulse_interpolator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         VAL_W        = gpi_pkg::VAL_W;
    localparam int         CFG_W        = gpi_pkg::CFG_W;
    localparam int         MAX_POINTS   = gpi_pkg::MAX_POINTS;
    localparam logic [1:0] MODE_LOAD    = gpi_pkg::MODE_LOAD;
    localparam logic [1:0] MODE_G2P     = gpi_pkg::MODE_G2P;
    localparam logic [1:0] MODE_P2G     = gpi_pkg::MODE_P2G;
    localparam logic [1:0] STATUS_OK    = gpi_pkg::STATUS_OK;
    localparam logic [1:0] STATUS_EMPTY = gpi_pkg::STATUS_EMPTY;

    localparam logic [1:0] MODE_SPARE  = 2'd3;
    localparam int         ITEM_TARGET = 775;
    localparam int         DRAIN_PAD   = 40;
    localparam int         CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [VAL_W-1:0] pulse;
        logic [VAL_W-1:0] gap;
        logic [1:0]       status;
    } conv_word_t;

    class conversion_checker;
        logic [VAL_W-1:0] tbl_pulse [MAX_POINTS];
        logic [VAL_W-1:0] tbl_gap   [MAX_POINTS];
        logic [CFG_W-1:0] count_reg;
        conv_word_t       pending [$];
        int error_count;
        int words_checked;
        int loads;
        int to_pulse;
        int to_gap;
        int empties;

        function new();
            tbl_pulse = '{500, 700, 900, 1050, 1150, 1200, 1250, 1300, 1400, 1500, 1600,
                          0, 0, 0, 0, 0};
            tbl_gap   = '{580, 560, 500, 440, 360, 290, 280, 240, 160, 60, 0,
                          0, 0, 0, 0, 0};
            count_reg = 5'd11;
        endfunction

        function void set_count(logic [CFG_W-1:0] v);
            count_reg = v;
        endfunction

        function int points_in_use();
            return (count_reg > MAX_POINTS) ? MAX_POINTS : int'(count_reg);
        endfunction

        // base + num/den, rounded half up, floored at zero
        function longint round_half_up(longint base, longint num, longint den);
            longint top;
            top = 2 * base * den + 2 * num + den;
            if (top < 0)
                top = 0;
            return top / (2 * den);
        endfunction

        function logic [VAL_W-1:0] pulse_for_gap(int n, longint g);
            longint lo, hi, ag, bg, ap, bp, v;
            lo = tbl_pulse[0];
            hi = tbl_pulse[n-1];
            ag = tbl_gap[0];
            bg = tbl_gap[n-1];
            if (n == 1 || g >= ag)
                return tbl_pulse[0];
            if (g <= bg)
                return tbl_pulse[n-1];
            for (int i = 0; i + 1 < n; i++)
            begin
                ag = tbl_gap[i];
                bg = tbl_gap[i+1];
                ap = tbl_pulse[i];
                bp = tbl_pulse[i+1];
                if (g <= ag && g >= bg)
                begin
                    if (ag == bg)
                        return ap[VAL_W-1:0];
                    v = round_half_up(ap, (ag - g) * (bp - ap), ag - bg);
                    // upper clamp first so the lower bound wins on a bad table
                    if (v > hi)
                        v = hi;
                    if (v < lo)
                        v = lo;
                    return v[VAL_W-1:0];
                end
            end
            return tbl_pulse[n-1];
        endfunction

        function logic [VAL_W-1:0] gap_for_pulse(int n, longint p);
            longint ag, bg, ap, bp, v;
            ap = tbl_pulse[0];
            bp = tbl_pulse[n-1];
            if (n == 1 || p <= ap)
                return tbl_gap[0];
            if (p >= bp)
                return tbl_gap[n-1];
            for (int i = 0; i + 1 < n; i++)
            begin
                ap = tbl_pulse[i];
                bp = tbl_pulse[i+1];
                ag = tbl_gap[i];
                bg = tbl_gap[i+1];
                if (p >= ap && p <= bp)
                begin
                    if (ap == bp)
                        return ag[VAL_W-1:0];
                    v = round_half_up(ag, (p - ap) * (bg - ag), bp - ap);
                    return v[VAL_W-1:0];
                end
            end
            return tbl_gap[n-1];
        endfunction

        function void take_item(logic [1:0] m, logic [3:0] idx,
                                logic [VAL_W-1:0] pp, logic [VAL_W-1:0] pg,
                                logic [VAL_W-1:0] qg, logic [VAL_W-1:0] qp);
            conv_word_t w;
            int n;
            w = '0;
            n = points_in_use();
            case (m)
                MODE_LOAD:
                begin
                    tbl_pulse[idx] = pp;
                    tbl_gap[idx]   = pg;
                    w.status       = STATUS_OK;
                    loads++;
                end
                MODE_G2P:
                begin
                    if (n == 0)
                    begin
                        w.status = STATUS_EMPTY;
                        empties++;
                    end
                    else
                    begin
                        w.pulse = pulse_for_gap(n, qg);
                        to_pulse++;
                    end
                end
                MODE_P2G:
                begin
                    if (n == 0)
                    begin
                        w.status = STATUS_EMPTY;
                        empties++;
                    end
                    else
                    begin
                        w.gap = gap_for_pulse(n, qp);
                        to_gap++;
                    end
                end
                default: ;
            endcase
            pending.push_back(w);
        endfunction

        function void check_word(logic [VAL_W-1:0] p, logic [VAL_W-1:0] g, logic [1:0] s);
            conv_word_t w;
            if (pending.size() == 0)
            begin
                $error("result word with nothing pending: pulse %0d gap %0d status %0d",
                       p, g, s);
                error_count++;
                return;
            end
            w = pending.pop_front();
            words_checked++;
            if (p !== w.pulse)
            begin
                $error("pulse_out: expected %0d, got %0d", w.pulse, p);
                error_count++;
            end
            if (g !== w.gap)
            begin
                $error("gap_out: expected %0d, got %0d", w.gap, g);
                error_count++;
            end
            if (s !== w.status)
            begin
                $error("status: expected %0d, got %0d", w.status, s);
                error_count++;
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [1:0]       mode = MODE_LOAD;
    logic [3:0]       point_index = '0;
    logic [VAL_W-1:0] point_pulse = '0;
    logic [VAL_W-1:0] point_gap = '0;
    logic [VAL_W-1:0] query_gap = '0;
    logic [VAL_W-1:0] query_pulse = '0;
    logic             point_count_we = 1'b0;
    logic [CFG_W-1:0] point_count = '0;
    logic             done;
    logic [VAL_W-1:0] pulse_out;
    logic [VAL_W-1:0] gap_out;
    logic [1:0]       status;

    conversion_checker sb;
    int items_sent;
    int count_writes;
    int burst_left;
    bit quiet;
    int cycle_count;

    gripper_gap_pulse_interpolator i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .point_index    (point_index),
        .point_pulse    (point_pulse),
        .point_gap      (point_gap),
        .query_gap      (query_gap),
        .query_pulse    (query_pulse),
        .point_count_we (point_count_we),
        .point_count    (point_count),
        .done           (done),
        .pulse_out      (pulse_out),
        .gap_out        (gap_out),
        .status         (status)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_word(pulse_out, gap_out, status);
    end

    function automatic logic [VAL_W-1:0] any12();
        return VAL_W'($urandom_range(0, 4095));
    endfunction

    // inside the table span, on a breakpoint, or anywhere
    function automatic logic [VAL_W-1:0] pick_value(bit want_gap, int n);
        int first, last, k;
        if (n == 0)
            return any12();
        k     = $urandom_range(0, n - 1);
        first = want_gap ? sb.tbl_gap[0]   : sb.tbl_pulse[0];
        last  = want_gap ? sb.tbl_gap[n-1] : sb.tbl_pulse[n-1];
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return VAL_W'($urandom_range(first, last));
            6, 7:             return want_gap ? sb.tbl_gap[k] : sb.tbl_pulse[k];
            default:          return any12();
        endcase
    endfunction

    task automatic send_item(logic [1:0] m, logic [3:0] idx,
                             logic [VAL_W-1:0] pp, logic [VAL_W-1:0] pg,
                             logic [VAL_W-1:0] qg, logic [VAL_W-1:0] qp);
        @(negedge clk);
        start       <= 1'b1;
        mode        <= m;
        point_index <= idx;
        point_pulse <= pp;
        point_gap   <= pg;
        query_gap   <= qg;
        query_pulse <= qp;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.take_item(m, idx, pp, pg, qg, qp);
        items_sent++;
    endtask

    task automatic idle(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // sender bursts with gaps between them
    task automatic pace();
        if (quiet)
            return;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 5) == 0)
                idle($urandom_range(13, 45));
            else
                idle($urandom_range(0, 12));
        end
        burst_left--;
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_count(logic [CFG_W-1:0] v);
        drain();
        @(negedge clk);
        point_count_we <= 1'b1;
        point_count    <= v;
        @(posedge clk);
        sb.set_count(v);
        count_writes++;
        @(negedge clk);
        point_count_we <= 1'b0;
    endtask

    task automatic load_ordered_table(int n);
        int p, g, step_max, step;
        step_max = (n > 1) ? 3840 / (n - 1) : 1;
        p = $urandom_range(0, 255);
        g = 4095 - $urandom_range(0, 255);
        for (int i = 0; i < n; i++)
        begin
            pace();
            send_item(MODE_LOAD, 4'(i), VAL_W'(p), VAL_W'(g), any12(), any12());
            // an occasional flat step gives zero-width segments
            step = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, step_max);
            p += step;
            step = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, step_max);
            g -= step;
            if (p > 4095)
                p = 4095;
            if (g < 0)
                g = 0;
        end
    endtask

    initial
    begin
        int plan [] = '{16, 0, 1, 2, 31, 11, 17, 5, 16, 3, 9, 14, 16, 7};
        int phase, n, qn, dice;
        logic [CFG_W-1:0] cfg;

        sb = new();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // factory table: ends, exact points, interior and half-way rounding
        send_item(MODE_G2P, 4'd0, 12'd0, 12'd0, 12'd4095, 12'd0);
        send_item(MODE_G2P, 4'd0, 12'd0, 12'd0, 12'd0, 12'd0);
        send_item(MODE_G2P, 4'd0, 12'd0, 12'd0, 12'd580, 12'd0);
        send_item(MODE_G2P, 4'd0, 12'd0, 12'd0, 12'd570, 12'd0);
        send_item(MODE_G2P, 4'd0, 12'd0, 12'd0, 12'd285, 12'd0);
        send_item(MODE_G2P, 4'd0, 12'd0, 12'd0, 12'd238, 12'd0);
        send_item(MODE_P2G, 4'd0, 12'd0, 12'd0, 12'd0, 12'd4095);
        send_item(MODE_P2G, 4'd0, 12'd0, 12'd0, 12'd0, 12'd0);
        send_item(MODE_P2G, 4'd0, 12'd0, 12'd0, 12'd0, 12'd505);
        send_item(MODE_P2G, 4'd0, 12'd0, 12'd0, 12'd0, 12'd1225);
        send_item(MODE_P2G, 4'd0, 12'd0, 12'd0, 12'd0, 12'd1302);
        send_item(MODE_SPARE, 4'd15, 12'd4095, 12'd4095, 12'd4095, 12'd4095);

        // empty table, then a single point
        write_count(5'd0);
        send_item(MODE_G2P, 4'd0, 12'd0, 12'd0, 12'd100, 12'd0);
        send_item(MODE_P2G, 4'd0, 12'd0, 12'd0, 12'd0, 12'd100);
        send_item(MODE_LOAD, 4'd15, 12'd4095, 12'd4095, 12'd0, 12'd0);
        write_count(5'd1);
        send_item(MODE_G2P, 4'd0, 12'd0, 12'd0, 12'd0, 12'd0);
        send_item(MODE_P2G, 4'd0, 12'd0, 12'd0, 12'd0, 12'd4095);

        // full-scale two-point table
        write_count(5'd2);
        send_item(MODE_LOAD, 4'd0, 12'd0, 12'd4095, 12'd0, 12'd0);
        send_item(MODE_LOAD, 4'd1, 12'd4095, 12'd0, 12'd0, 12'd0);
        send_item(MODE_G2P, 4'd0, 12'd0, 12'd0, 12'd2048, 12'd0);
        send_item(MODE_P2G, 4'd0, 12'd0, 12'd0, 12'd0, 12'd2048);

        // count above the table size saturates
        write_count(5'd31);
        send_item(MODE_G2P, 4'd0, 12'd0, 12'd0, 12'd300, 12'd0);
        send_item(MODE_P2G, 4'd0, 12'd0, 12'd0, 12'd0, 12'd1000);
        send_item(MODE_G2P, 4'd0, 12'd0, 12'd0, 12'd4000, 12'd0);

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (phase < plan.size())
                cfg = CFG_W'(plan[phase]);
            else if ($urandom_range(0, 7) == 0)
                cfg = CFG_W'($urandom_range(17, 31));
            else
                cfg = CFG_W'($urandom_range(0, 16));
            write_count(cfg);
            n = (cfg > MAX_POINTS) ? MAX_POINTS : int'(cfg);
            quiet = ($urandom_range(0, 3) == 0);
            burst_left = 0;

            if (n == 0 || phase % 4 == 3)
            begin
                // scrambled table
                for (int i = 0; i < ((n == 0) ? 2 : n); i++)
                begin
                    pace();
                    send_item(MODE_LOAD, 4'($urandom_range(0, 15)), any12(), any12(),
                              any12(), any12());
                end
            end
            else
                load_ordered_table(n);

            qn = $urandom_range(30, 60);
            for (int q = 0; q < qn && items_sent < ITEM_TARGET; q++)
            begin
                if (q == qn / 2)
                    drain();
                pace();
                dice = $urandom_range(0, 19);
                if (dice < 9)
                    send_item(MODE_G2P, 4'($urandom_range(0, 15)), any12(), any12(),
                              pick_value(1'b1, n), any12());
                else if (dice < 18)
                    send_item(MODE_P2G, 4'($urandom_range(0, 15)), any12(), any12(),
                              any12(), pick_value(1'b0, n));
                else if (dice == 18)
                    send_item(MODE_LOAD, 4'($urandom_range(0, 15)), any12(), any12(),
                              any12(), any12());
                else
                    send_item(MODE_SPARE, 4'($urandom_range(0, 15)), any12(), any12(),
                              any12(), any12());
            end
            phase++;
        end

        @(negedge clk);
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAD) @(posedge clk);

        $display("run: %0d words, %0d loads, %0d gap->pulse, %0d pulse->gap, %0d empty",
                 sb.words_checked, sb.loads, sb.to_pulse, sb.to_gap, sb.empties);
        $display("run: %0d point count settings over %0d phases", count_writes, phase);
        if (sb.error_count == 0 && sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
